>>> design/dbab_pkg.sv
// Shared types, constants and the loop-counter advance function of the affine double buffer.
`default_nettype none

package dbab_pkg;

    // Defaults of the top-level parameters.
    localparam int DEPTH_DEF      = 1024;
    localparam int DIMS_DEF       = 6;
    localparam int PORTS_DEF      = 2;
    localparam int DATA_WIDTH_DEF = 16;

    // Register field layout.
    localparam int FIELD_W    = 10;
    localparam int MAX_DIMS   = 6;
    localparam int LANES      = 2;
    localparam int RANGES_W   = MAX_DIMS * FIELD_W;
    localparam int STARTS_W   = LANES * FIELD_W;
    localparam int CFG_DATA_W = RANGES_W;
    localparam int CFG_INDEX_W = 3;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_RANGES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_STRIDES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRITE_STARTS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_RANGES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_STRIDES  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_STARTS   = 3'd5;

    // Request codes.
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    // Payload widths.
    localparam int DATA_FIELD_W = 16;
    localparam int TDATA_W      = LANES * DATA_FIELD_W;
    localparam int TUSER_OUT_W  = 3;

    // Address arithmetic: a product of two fields and the full lane sum.
    localparam int PROD_W = 2 * FIELD_W;
    localparam int SUM_W  = 23;

    // Result queue depth; it covers the pipeline plus slack for a full rate.
    localparam int OUTQ_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef logic [MAX_DIMS-1:0][FIELD_W-1:0] cnt_vec_t;

    typedef struct packed {
        op_t                     op;
        logic                    bank;
        logic [DATA_FIELD_W-1:0] data0;
        logic [DATA_FIELD_W-1:0] data1;
        logic                    valid_res;
        logic                    rejected;
        logic                    swapped;
    } item_t;

    typedef struct packed {
        logic [DATA_FIELD_W-1:0] data_out_0;
        logic [DATA_FIELD_W-1:0] data_out_1;
        logic                    valid_res;
        logic                    rejected;
        logic                    swapped;
    } result_t;

    typedef struct packed {
        cnt_vec_t cnt;
        logic     wrap;
    } adv_t;

    // Steps a counter nest by one, innermost dimension first. A zero range acts as one,
    // and a counter whose next value reaches or passes its range wraps and carries.
    function automatic adv_t advance(input cnt_vec_t cnt, input logic [RANGES_W-1:0] ranges,
                                     input int dims);
        adv_t               res;
        logic               carry;
        logic [FIELD_W-1:0] rng;
        logic [FIELD_W:0]   nxt;
        res.cnt = cnt;
        carry   = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            rng = ranges[d*FIELD_W +: FIELD_W];
            if (rng == '0)
            begin
                rng = FIELD_W'(1);
            end
            nxt = {1'b0, cnt[d]} + (FIELD_W+1)'(1);
            if (carry && (d < dims))
            begin
                if (nxt < {1'b0, rng})
                begin
                    res.cnt[d] = nxt[FIELD_W-1:0];
                    carry      = 1'b0;
                end
                else
                begin
                    res.cnt[d] = '0;
                end
            end
        end
        res.wrap = carry;
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/dbab_ram.sv
// Generic RAM with one write port and two registered read ports, read-during-write returns new data.
`default_nettype none

module dbab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata0_reg <= (we && (waddr == raddr0)) ? wdata : mem_reg[raddr0];
        rdata1_reg <= (we && (waddr == raddr1)) ? wdata : mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

>>> design/dbab_ctrl.sv
// Loop counters, done flags and bank swap control for the affine double buffer.
`default_nettype none

module dbab_ctrl
    import dbab_pkg::*;
#(
    parameter int DIMS = DIMS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic [REQ_W-1:0]        req_type,
    input  wire logic [DATA_FIELD_W-1:0] data0,
    input  wire logic [DATA_FIELD_W-1:0] data1,
    input  wire logic [RANGES_W-1:0]     write_ranges,
    input  wire logic [RANGES_W-1:0]     read_ranges,
    output item_t                        item,
    output cnt_vec_t                     cnt
);

    cnt_vec_t wcnt_reg, wcnt_next;
    cnt_vec_t rcnt_reg, rcnt_next;
    logic     wfin_reg, wfin_next;
    logic     rfin_reg, rfin_next;
    logic     front_reg, front_next;
    logic     once_reg, once_next;

    cnt_vec_t wcnt_base;
    logic     wfin_base;
    adv_t     wadv;
    adv_t     radv;
    op_t      op;
    logic     rej;
    logic     sw;
    logic     bank;

    always_comb
    begin
        // A restart clears the write nest before the access is judged.
        wcnt_base = wcnt_reg;
        wfin_base = wfin_reg;
        if (req_type == REQ_RESTART)
        begin
            wcnt_base = '0;
            wfin_base = 1'b0;
        end
        wadv = advance(wcnt_base, write_ranges, DIMS);
        radv = advance(rcnt_reg, read_ranges, DIMS);

        wcnt_next  = wcnt_reg;
        rcnt_next  = rcnt_reg;
        wfin_next  = wfin_reg;
        rfin_next  = rfin_reg;
        front_next = front_reg;
        once_next  = once_reg;
        op         = OP_NONE;
        rej        = 1'b0;
        bank       = front_reg;
        cnt        = '0;

        case (req_type)
            REQ_WRITE, REQ_RESTART:
            begin
                wcnt_next = wcnt_base;
                wfin_next = wfin_base;
                if (wfin_base)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    op        = OP_WRITE;
                    bank      = ~front_reg;
                    cnt       = wcnt_base;
                    wcnt_next = wadv.cnt;
                    wfin_next = wadv.wrap;
                end
            end
            REQ_READ:
            begin
                if (rfin_reg)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    op        = OP_READ;
                    cnt       = rcnt_reg;
                    rcnt_next = radv.cnt;
                    rfin_next = radv.wrap;
                end
            end
            default:
            begin
                rej = 1'b0;
            end
        endcase

        // Both nests done: swap banks and start both over.
        sw = (op != OP_NONE) && wfin_next && rfin_next;
        if (sw)
        begin
            front_next = ~front_reg;
            wcnt_next  = '0;
            rcnt_next  = '0;
            wfin_next  = 1'b0;
            rfin_next  = 1'b0;
            once_next  = 1'b1;
        end

        item.op        = op;
        item.bank      = bank;
        item.data0     = data0;
        item.data1     = data1;
        item.valid_res = once_next;
        item.rejected  = rej;
        item.swapped   = sw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg  <= '0;
            rcnt_reg  <= '0;
            wfin_reg  <= 1'b0;
            rfin_reg  <= 1'b0;
            front_reg <= 1'b0;
            once_reg  <= 1'b0;
        end
        else if (in_valid)
        begin
            wcnt_reg  <= wcnt_next;
            rcnt_reg  <= rcnt_next;
            wfin_reg  <= wfin_next;
            rfin_reg  <= rfin_next;
            front_reg <= front_next;
            once_reg  <= once_next;
        end
    end

endmodule

`default_nettype wire

>>> design/dbab_addr.sv
// Address pipeline: stride products, lane sums and reduction modulo the bank depth.
`default_nettype none

module dbab_addr
    import dbab_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int DIMS  = DIMS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    input  wire item_t                                 in_item,
    input  wire cnt_vec_t                              in_cnt,
    input  wire logic [RANGES_W-1:0]                   write_strides,
    input  wire logic [STARTS_W-1:0]                   write_starts,
    input  wire logic [RANGES_W-1:0]                   read_strides,
    input  wire logic [STARTS_W-1:0]                   read_starts,
    output logic                                       out_valid,
    output item_t                                      out_item,
    output logic      [LANES-1:0][$clog2(DEPTH)-1:0]   out_addr
);

    localparam int AW      = $clog2(DEPTH);
    localparam int RW      = AW + 1;
    localparam int DEPTH_W = $clog2(DEPTH + 1);
    localparam logic [SUM_W-1:0]   RECIP   = SUM_W'((1 << SUM_W) / DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(DEPTH);
    localparam logic [RW-1:0]      DEPTH_R = RW'(DEPTH);

    logic v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    item_t item2_reg, item3_reg, item4_reg, item5_reg, item6_reg;
    cnt_vec_t cnt2_reg;

    logic [MAX_DIMS-1:0][PROD_W-1:0] prod3_reg, prod3_next;
    logic [LANES-1:0][SUM_W-1:0]     x4_reg, x4_next;
    logic [LANES-1:0][SUM_W-1:0]     x5_reg;
    logic [LANES-1:0][SUM_W-1:0]     q5_reg, q5_next;
    logic [LANES-1:0][RW-1:0]        r6_reg, r6_next;

    logic [RANGES_W-1:0]          stride_sel;
    logic [STARTS_W-1:0]          start_sel;
    logic [SUM_W-1:0]             base;
    logic [2*SUM_W-1:0]           recip_prod [LANES];
    logic [SUM_W+DEPTH_W-1:0]     qd_prod [LANES];
    logic [SUM_W-1:0]             diff [LANES];

    // Stride products.
    always_comb
    begin
        stride_sel = (item2_reg.op == OP_READ) ? read_strides : write_strides;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (d < DIMS)
            begin
                prod3_next[d] = {{FIELD_W{1'b0}}, cnt2_reg[d]}
                              * {{FIELD_W{1'b0}}, stride_sel[d*FIELD_W +: FIELD_W]};
            end
            else
            begin
                prod3_next[d] = '0;
            end
        end
    end

    // Lane sums: base address plus the start offset of each lane.
    always_comb
    begin
        start_sel = (item3_reg.op == OP_READ) ? read_starts : write_starts;
        base = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            base = base + SUM_W'(prod3_reg[d]);
        end
        for (int p = 0; p < LANES; p++)
        begin
            x4_next[p] = base + SUM_W'(start_sel[p*FIELD_W +: FIELD_W]);
        end
    end

    // Quotient estimate by the reciprocal; it is exact or one short.
    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            recip_prod[p] = {{SUM_W{1'b0}}, x4_reg[p]} * {{SUM_W{1'b0}}, RECIP};
            q5_next[p]    = recip_prod[p][2*SUM_W-1:SUM_W];
        end
    end

    // Remainder estimate, below twice the depth.
    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            qd_prod[p] = {{DEPTH_W{1'b0}}, q5_reg[p]} * {{SUM_W{1'b0}}, DEPTH_C};
            diff[p]    = x5_reg[p] - qd_prod[p][SUM_W-1:0];
            r6_next[p] = diff[p][RW-1:0];
        end
    end

    // Final correction.
    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            if (r6_reg[p] >= DEPTH_R)
            begin
                out_addr[p] = AW'(r6_reg[p] - DEPTH_R);
            end
            else
            begin
                out_addr[p] = r6_reg[p][AW-1:0];
            end
        end
    end

    assign out_valid = v6_reg;
    assign out_item  = item6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item2_reg <= in_item;
        cnt2_reg  <= in_cnt;
        item3_reg <= item2_reg;
        prod3_reg <= prod3_next;
        item4_reg <= item3_reg;
        x4_reg    <= x4_next;
        item5_reg <= item4_reg;
        x5_reg    <= x4_reg;
        q5_reg    <= q5_next;
        item6_reg <= item5_reg;
        r6_reg    <= r6_next;
    end

endmodule

`default_nettype wire

>>> design/dbab_outq.sv
// Result queue that decouples the fixed-latency pipeline from the output handshake.
`default_nettype none

module dbab_outq
    import dbab_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output logic         out_valid,
    output result_t      head_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t        entries_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head_data = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> design/double_buffered_affine_buffer.sv
// Top level of the ping-pong buffer with affine write and read address generators.
`default_nettype none

// Ping-pong buffer with two banks of DEPTH words and two nested-loop address generators.
// Each item on the input stream is a write (req_type 0), a read (1) or a restart of the
// write generator followed by a write (2); every item yields exactly one result item, in
// order. The block takes one item per clock cycle in steady state; each result passes
// through the address pipeline (stride products, lane sum, two steps of reduction
// modulo DEPTH) and the registered read of the bank memory. A 16-entry result queue
// lets input continue while results wait, so input stalls only once 16 items are
// outstanding. After reset the block clears both bank memories, one entry per cycle,
// and takes no items until that is done; configuration writes are taken at any time,
// but the user must make them only while no item is in flight, as the block itself
// does not enforce this. The two write lanes of one item may hit any addresses, so
// each bank word is held as the XOR of two memories, one written by each lane; lane 1
// wins when both lanes name the same address.

module double_buffered_affine_buffer
    import dbab_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DIMS       = DIMS_DEF,
    parameter int PORTS      = PORTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // data_in_0 [15:0], data_in_1 [31:16]
    input  wire logic [TDATA_W-1:0]     s_axis_tdata,
    // req_type [1:0]
    input  wire logic [REQ_W-1:0]       s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // data_out_0 [15:0], data_out_1 [31:16]
    output logic      [TDATA_W-1:0]     m_axis_tdata,
    // valid_res [0], rejected [1], swapped [2]
    output logic      [TUSER_OUT_W-1:0] m_axis_tuser,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW        = $clog2(DEPTH);
    localparam int RAM_AW    = AW + 1;
    localparam int RAM_DEPTH = 2 * (1 << AW);
    localparam int SW        = (DATA_WIDTH < DATA_FIELD_W) ? DATA_WIDTH : DATA_FIELD_W;
    localparam int OCW       = $clog2(OUTQ_DEPTH + 1);

    // Configuration registers.
    logic [RANGES_W-1:0] write_ranges_reg;
    logic [RANGES_W-1:0] write_strides_reg;
    logic [STARTS_W-1:0] write_starts_reg;
    logic [RANGES_W-1:0] read_ranges_reg;
    logic [RANGES_W-1:0] read_strides_reg;
    logic [STARTS_W-1:0] read_starts_reg;

    // Input register.
    logic                    in_valid_reg;
    logic [REQ_W-1:0]        in_req_reg;
    logic [DATA_FIELD_W-1:0] in_data0_reg;
    logic [DATA_FIELD_W-1:0] in_data1_reg;

    logic in_accept;
    logic out_pop;

    // Control and address pipeline.
    item_t                   ctrl_item;
    cnt_vec_t                ctrl_cnt;
    logic                    p6_valid;
    item_t                   p6_item;
    logic [LANES-1:0][AW-1:0] p6_addr;

    // Memory access stage.
    logic                     p7_valid_reg;
    item_t                    p7_item_reg;
    logic [LANES-1:0][AW-1:0] p7_addr_reg;

    // Clearing pass after reset.
    logic              clr_active_reg;
    logic [RAM_AW-1:0] clr_addr_reg;

    // Items accepted and not yet taken at the output.
    logic [OCW-1:0] out_cnt_reg, out_cnt_next;

    // Bank memories: lane 0 memory A, lane 1 memory B.
    logic              a_we;
    logic [RAM_AW-1:0] a_waddr;
    logic [SW-1:0]     a_wdata;
    logic [SW-1:0]     a_rd0, a_rd1;
    logic [SW-1:0]     b_rd0, b_rd1;
    logic [RAM_AW-1:0] rd_addr0, rd_addr1;
    logic              p7_write;

    result_t res;
    result_t q_data;
    logic    q_valid;

    assign cfg_ready = 1'b1;

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ranges_reg  <= '0;
            write_strides_reg <= '0;
            write_starts_reg  <= '0;
            read_ranges_reg   <= '0;
            read_strides_reg  <= '0;
            read_starts_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WRITE_RANGES:  write_ranges_reg  <= cfg_data[RANGES_W-1:0];
                REG_WRITE_STRIDES: write_strides_reg <= cfg_data[RANGES_W-1:0];
                REG_WRITE_STARTS:  write_starts_reg  <= cfg_data[STARTS_W-1:0];
                REG_READ_RANGES:   read_ranges_reg   <= cfg_data[RANGES_W-1:0];
                REG_READ_STRIDES:  read_strides_reg  <= cfg_data[RANGES_W-1:0];
                REG_READ_STARTS:   read_starts_reg   <= cfg_data[STARTS_W-1:0];
                default:           write_ranges_reg  <= write_ranges_reg;
            endcase
        end
    end

    // Input side: ready once the memories are cleared and while the queue has room for
    // every item still outstanding.
    assign s_axis_tready = !clr_active_reg && (out_cnt_reg < OCW'(OUTQ_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_req_reg   <= s_axis_tuser;
            in_data0_reg <= s_axis_tdata[DATA_FIELD_W-1:0];
            in_data1_reg <= s_axis_tdata[TDATA_W-1:DATA_FIELD_W];
        end
    end

    always_comb
    begin
        case ({in_accept, out_pop})
            2'b10:   out_cnt_next = out_cnt_reg + OCW'(1);
            2'b01:   out_cnt_next = out_cnt_reg - OCW'(1);
            default: out_cnt_next = out_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
        end
    end

    // Counters, done flags and the bank swap decision for the item in the input register.
    dbab_ctrl #(
        .DIMS (DIMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid_reg),
        .req_type     (in_req_reg),
        .data0        (in_data0_reg),
        .data1        (in_data1_reg),
        .write_ranges (write_ranges_reg),
        .read_ranges  (read_ranges_reg),
        .item         (ctrl_item),
        .cnt          (ctrl_cnt)
    );

    // Lane addresses within a bank.
    dbab_addr #(
        .DEPTH (DEPTH),
        .DIMS  (DIMS)
    ) u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid_reg),
        .in_item       (ctrl_item),
        .in_cnt        (ctrl_cnt),
        .write_strides (write_strides_reg),
        .write_starts  (write_starts_reg),
        .read_strides  (read_strides_reg),
        .read_starts   (read_starts_reg),
        .out_valid     (p6_valid),
        .out_item      (p6_item),
        .out_addr      (p6_addr)
    );

    // Both memories are read at the two lane addresses of every item. A read item uses
    // the words directly; a write item uses them to form the XOR it stores in the next cycle.
    assign rd_addr0 = {p6_item.bank, p6_addr[0]};
    assign rd_addr1 = {p6_item.bank, p6_addr[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_valid_reg <= 1'b0;
        end
        else
        begin
            p7_valid_reg <= p6_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p7_item_reg <= p6_item;
        p7_addr_reg <= p6_addr;
    end

    // Clearing pass: walk every memory entry once after reset, writing zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + RAM_AW'(1);
            if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign p7_write = p7_valid_reg && (p7_item_reg.op == OP_WRITE);

    // Lane 0 stores its data XOR the lane 1 word, so the pair reads back as lane 0 data.
    // When both lanes name the same address only lane 1 writes, and it wins.
    always_comb
    begin
        if (clr_active_reg)
        begin
            a_we    = 1'b1;
            a_waddr = clr_addr_reg;
            a_wdata = '0;
        end
        else
        begin
            a_we    = p7_write && !((PORTS > 1) && (p7_addr_reg[0] == p7_addr_reg[1]));
            a_waddr = {p7_item_reg.bank, p7_addr_reg[0]};
            a_wdata = p7_item_reg.data0[SW-1:0] ^ b_rd0;
        end
    end

    dbab_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_DEPTH)
    ) u_ram_a (
        .clk    (clk),
        .we     (a_we),
        .waddr  (a_waddr),
        .wdata  (a_wdata),
        .raddr0 (rd_addr0),
        .raddr1 (rd_addr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    generate
        if (PORTS > 1)
        begin : g_lane1
            logic              b_we;
            logic [RAM_AW-1:0] b_waddr;
            logic [SW-1:0]     b_wdata;

            // Lane 1 stores its data XOR the current lane 0 word at its address.
            always_comb
            begin
                if (clr_active_reg)
                begin
                    b_we    = 1'b1;
                    b_waddr = clr_addr_reg;
                    b_wdata = '0;
                end
                else
                begin
                    b_we    = p7_write;
                    b_waddr = {p7_item_reg.bank, p7_addr_reg[1]};
                    b_wdata = p7_item_reg.data1[SW-1:0] ^ a_rd1;
                end
            end

            dbab_ram #(
                .WIDTH (SW),
                .DEPTH (RAM_DEPTH)
            ) u_ram_b (
                .clk    (clk),
                .we     (b_we),
                .waddr  (b_waddr),
                .wdata  (b_wdata),
                .raddr0 (rd_addr0),
                .raddr1 (rd_addr1),
                .rdata0 (b_rd0),
                .rdata1 (b_rd1)
            );
        end
        else
        begin : g_no_lane1
            assign b_rd0 = '0;
            assign b_rd1 = '0;
        end
    endgenerate

    // Result of the item in the memory stage; data is zero unless it is a read.
    always_comb
    begin
        res.data_out_0 = '0;
        res.data_out_1 = '0;
        if (p7_item_reg.op == OP_READ)
        begin
            res.data_out_0 = DATA_FIELD_W'(a_rd0 ^ b_rd0);
            if (PORTS > 1)
            begin
                res.data_out_1 = DATA_FIELD_W'(a_rd1 ^ b_rd1);
            end
        end
        res.valid_res = p7_item_reg.valid_res;
        res.rejected  = p7_item_reg.rejected;
        res.swapped   = p7_item_reg.swapped;
    end

    dbab_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p7_valid_reg),
        .push_data (res),
        .pop       (out_pop),
        .out_valid (q_valid),
        .head_data (q_data)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {q_data.data_out_1, q_data.data_out_0};
    assign m_axis_tuser  = {q_data.swapped, q_data.rejected, q_data.valid_res};

endmodule

`default_nettype wire
